// ===== sv/fsa_pkg.sv =====
package fsa_pkg;

  // Fixed field widths
  localparam int unsigned RunW     = 4;
  localparam int unsigned LenW     = 16;
  localparam int unsigned FrameW   = 32;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned LedsW    = 10;
  localparam int unsigned SeenW    = 4;
  localparam int unsigned NumLedRegs = 4;
  localparam int unsigned LedIdxW  = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned RunsDefault = 4;

  // Per-LED byte count and header overhead of a packet
  localparam logic [LenW-1:0] BytesPerLed = 16'd3;
  localparam logic [LenW-1:0] HeaderBytes = 16'd4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegLedsRun0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLedsRun1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLedsRun2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLedsRun3 = 3'd3;

  // Result status codes
  localparam logic [StatusW-1:0] StAccepted = 3'd0;
  localparam logic [StatusW-1:0] StBadRun   = 3'd1;
  localparam logic [StatusW-1:0] StBadLen   = 3'd2;
  localparam logic [StatusW-1:0] StStale    = 3'd3;
  localparam logic [StatusW-1:0] StNextOld  = 3'd4;

  typedef struct packed {
    logic [RunW-1:0]   run_number;
    logic [LenW-1:0]   packet_length;
    logic [FrameW-1:0] frame_number;
  } in_beat_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               dest_slot;
    logic               frame_complete;
    logic               slots_swapped;
  } out_beat_t;

  typedef struct packed {
    logic [1:0][FrameW-1:0] frame;
    logic [1:0][SeenW-1:0]  seen;
    logic                   cur;
  } slot_state_t;

  // a is ahead of b by a signed wrapping difference
  function automatic logic newer_than(logic [FrameW-1:0] a, logic [FrameW-1:0] b);
    logic [FrameW-1:0] d;
    d = a - b;
    return (d != '0) && !d[FrameW-1];
  endfunction

endpackage

// ===== sv/frame_slot_assembler.sv =====
// Frame slot assembler.
// Input channel (in_valid_i / in_stall_o / in_data_i): one packet header per
// beat: run number, packet length and frame number.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result per
// header: status, target slot, frame-complete and slot-swap flags.
// Configuration: cfg_we_i writes cfg_data_i into the LED count of run
// cfg_idx_i; indexes 4 and above are ignored.
// The header register is loaded when a header is accepted; the placement
// logic then updates the slot state and loads the result register as soon
// as the result register is empty or its result is being taken.
// Throughput is one header per cycle while the receiver does not stall; the
// limit is the slot state update, registered and read back by the next header.
// A result waiting in the output register does not block acceptance; only
// when both the header and the result register are full and the receiver
// stalls does in_stall_o rise, and both registers then hold.
// Reset empties both slots (frame number 0, no runs seen), selects slot 0 as
// current and clears the LED counts.
module frame_slot_assembler #(
  parameter int unsigned RUNS = fsa_pkg::RunsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  fsa_pkg::in_beat_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output fsa_pkg::out_beat_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [fsa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fsa_pkg::LedsW-1:0]    cfg_data_i
);

  logic [fsa_pkg::NumLedRegs-1:0][fsa_pkg::LedsW-1:0] leds_q;
  fsa_pkg::in_beat_t    hdr_q;
  logic                 hdr_valid_q;
  fsa_pkg::slot_state_t state_q, state_d;
  fsa_pkg::out_beat_t   res_q, res_d;
  logic                 res_valid_q;
  logic                 res_hold, advance, take;

  // handshake
  assign res_hold   = res_valid_q && out_stall_i;
  assign advance    = hdr_valid_q && !res_hold;
  assign in_stall_o = hdr_valid_q && res_hold;
  assign take       = in_valid_i && !in_stall_o;

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  fsa_place #(
    .RUNS(RUNS)
  ) u_place (
    .hdr_i  (hdr_q),
    .leds_i (leds_q),
    .state_i(state_q),
    .state_o(state_d),
    .res_o  (res_d)
  );

  // LED count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leds_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fsa_pkg::RegLedsRun0: leds_q[0] <= cfg_data_i;
        fsa_pkg::RegLedsRun1: leds_q[1] <= cfg_data_i;
        fsa_pkg::RegLedsRun2: leds_q[2] <= cfg_data_i;
        fsa_pkg::RegLedsRun3: leds_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control and slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (take) begin
        hdr_valid_q <= 1'b1;
      end else if (advance) begin
        hdr_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!res_hold) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      hdr_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== sv/fsa_place.sv =====
module fsa_place #(
  parameter int unsigned RUNS = fsa_pkg::RunsDefault
) (
  input  fsa_pkg::in_beat_t                                   hdr_i,
  input  logic [fsa_pkg::NumLedRegs-1:0][fsa_pkg::LedsW-1:0]  leds_i,
  input  fsa_pkg::slot_state_t                                state_i,
  output fsa_pkg::slot_state_t                                state_o,
  output fsa_pkg::out_beat_t                                  res_o
);

  localparam logic [fsa_pkg::SeenW-1:0] AllRuns = fsa_pkg::SeenW'((1 << RUNS) - 1);

  logic                        cur, nxt;
  logic [fsa_pkg::FrameW-1:0]  frame, cur_frame, nxt_frame;
  logic [fsa_pkg::LenW-1:0]    exp_len;
  logic                        bad_run, bad_len;
  logic                        hit_cur, hit_nxt, newer, open_ok;
  logic                        tgt;
  logic [fsa_pkg::SeenW-1:0]   seen_base, seen_new;
  logic                        complete;

  always_comb begin
    cur       = state_i.cur;
    nxt       = ~state_i.cur;
    frame     = hdr_i.frame_number;
    cur_frame = state_i.frame[cur];
    nxt_frame = state_i.frame[nxt];

    // header checks
    bad_run = hdr_i.run_number >= fsa_pkg::RunW'(RUNS);
    exp_len = {6'd0, leds_i[hdr_i.run_number[fsa_pkg::LedIdxW-1:0]]} * fsa_pkg::BytesPerLed
              + fsa_pkg::HeaderBytes;
    bad_len = hdr_i.packet_length != exp_len;

    // slot placement, in priority order
    hit_cur = (frame == cur_frame) || (cur_frame == '0);
    hit_nxt = frame == nxt_frame;
    newer   = fsa_pkg::newer_than(frame, cur_frame);
    open_ok = (nxt_frame == '0) || fsa_pkg::newer_than(nxt_frame, frame);
    tgt     = hit_cur ? cur : nxt;

    // run bits of the target; a freshly opened next slot starts empty
    seen_base = (!hit_cur && !hit_nxt) ? '0 : state_i.seen[tgt];
    seen_new  = seen_base | (fsa_pkg::SeenW'(1) << hdr_i.run_number[fsa_pkg::LedIdxW-1:0]);
    complete  = (seen_new & AllRuns) == AllRuns;

    state_o = state_i;
    res_o   = '0;

    if (bad_run) begin
      res_o.status = fsa_pkg::StBadRun;
    end else if (bad_len) begin
      res_o.status = fsa_pkg::StBadLen;
    end else if (!hit_cur && !hit_nxt && !newer) begin
      res_o.status = fsa_pkg::StStale;
    end else if (!hit_cur && !hit_nxt && !open_ok) begin
      res_o.status = fsa_pkg::StNextOld;
    end else begin
      state_o.frame[tgt] = frame;
      state_o.seen[tgt]  = seen_new;
      res_o.status         = fsa_pkg::StAccepted;
      res_o.dest_slot      = tgt;
      res_o.frame_complete = complete;
      // next slot done: it becomes current, old current is emptied
      if ((tgt == nxt) && complete) begin
        state_o.cur        = nxt;
        state_o.frame[cur] = '0;
        state_o.seen[cur]  = '0;
        res_o.slots_swapped = 1'b1;
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RUNS = fsa_pkg::RunsDefault;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_HEADERS = 163;
  localparam int unsigned DRAIN_CYCLES = 4;

  localparam logic [fsa_pkg::CfgIdxW-1:0] LED_REG [fsa_pkg::NumLedRegs] =
    '{fsa_pkg::RegLedsRun0, fsa_pkg::RegLedsRun1, fsa_pkg::RegLedsRun2,
      fsa_pkg::RegLedsRun3};

  // Fixed results used in the directed rows
  localparam fsa_pkg::out_beat_t BAD_RUN  = '{fsa_pkg::StBadRun, 1'b0, 1'b0, 1'b0};
  localparam fsa_pkg::out_beat_t BAD_LEN  = '{fsa_pkg::StBadLen, 1'b0, 1'b0, 1'b0};
  localparam fsa_pkg::out_beat_t STALE    = '{fsa_pkg::StStale, 1'b0, 1'b0, 1'b0};
  localparam fsa_pkg::out_beat_t NEXT_OLD = '{fsa_pkg::StNextOld, 1'b0, 1'b0, 1'b0};
  localparam fsa_pkg::out_beat_t NO_WANT  = '0;

  typedef struct packed {
    fsa_pkg::in_beat_t  hdr;
    logic               typed;
    fsa_pkg::out_beat_t want;
  } row_t;

  // Directed rows; LED counts are 0, 1023, 5, 100, so lengths are 4, 3073, 19, 304
  localparam int unsigned DIRECTED_ROWS = 21;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{4'd15, 16'd0,     32'h0000_0000}, 1'b1, BAD_RUN},
    '{'{4'd4,  16'd4,     32'hFFFF_FFFF}, 1'b1, BAD_RUN},
    '{'{4'd0,  16'd5,     32'h0000_0001}, 1'b1, BAD_LEN},
    '{'{4'd1,  16'hFFFF,  32'h0000_0001}, 1'b1, BAD_LEN},
    // frame zero lands in the empty current slot
    '{'{4'd3,  16'd304,   32'h0000_0000}, 1'b0, NO_WANT},
    // empty current slot takes the frame and keeps its run bits
    '{'{4'd0,  16'd4,     32'h0000_000A}, 1'b0, NO_WANT},
    '{'{4'd1,  16'd3073,  32'h0000_000A}, 1'b0, NO_WANT},
    '{'{4'd2,  16'd19,    32'h0000_0005}, 1'b1, STALE},
    // newer frame opens the next slot
    '{'{4'd2,  16'd19,    32'h0000_000C}, 1'b0, NO_WANT},
    // earlier newer frame reopens the next slot
    '{'{4'd3,  16'd304,   32'h0000_000B}, 1'b0, NO_WANT},
    '{'{4'd0,  16'd4,     32'h0000_000C}, 1'b1, NEXT_OLD},
    '{'{4'd2,  16'd19,    32'h0000_000A}, 1'b0, NO_WANT},
    '{'{4'd3,  16'd304,   32'h0000_000A}, 1'b0, NO_WANT},
    '{'{4'd0,  16'd4,     32'h0000_000B}, 1'b0, NO_WANT},
    '{'{4'd1,  16'd3073,  32'h0000_000B}, 1'b0, NO_WANT},
    // next slot completes, slots swap
    '{'{4'd2,  16'd19,    32'h0000_000B}, 1'b0, NO_WANT},
    // frame zero matches the emptied next slot
    '{'{4'd0,  16'd4,     32'h0000_0000}, 1'b0, NO_WANT},
    // exactly half the range ahead counts as behind
    '{'{4'd1,  16'd3073,  32'h8000_000B}, 1'b1, STALE},
    '{'{4'd1,  16'd3073,  32'h8000_000A}, 1'b0, NO_WANT},
    '{'{4'd1,  16'd3073,  32'hFFFF_FFFF}, 1'b1, STALE},
    '{'{4'd15, 16'hFFFF,  32'hFFFF_FFFF}, 1'b1, BAD_RUN}
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  fsa_pkg::in_beat_t              in_data_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  fsa_pkg::out_beat_t             out_data_o;
  logic                           cfg_we_i = 1'b0;
  logic [fsa_pkg::CfgIdxW-1:0]    cfg_idx_i = '0;
  logic [fsa_pkg::LedsW-1:0]      cfg_data_i = '0;

  // Predictor state: LED counts and the two frame slots
  logic [fsa_pkg::LedsW-1:0]      led_cfg [fsa_pkg::NumLedRegs];
  logic [fsa_pkg::LedsW-1:0]      led_plan [fsa_pkg::NumLedRegs];
  logic [fsa_pkg::FrameW-1:0]     slot_frame [2];
  logic [fsa_pkg::SeenW-1:0]      slot_runs [2];
  logic                           live_slot;

  fsa_pkg::out_beat_t             pending_results [$];
  logic [fsa_pkg::FrameW-1:0]     frame_base;
  int unsigned                    gap_max;
  int unsigned                    stall_max;
  int unsigned                    stall_left;
  int unsigned                    mismatch_count;
  int unsigned                    results_seen;
  int unsigned                    headers_sent;
  int unsigned                    swap_count;
  int unsigned                    complete_count;
  int unsigned                    status_hits [8];

  frame_slot_assembler #(
    .RUNS(RUNS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Wrapping compare: a is ahead of b by less than half the range
  function automatic logic frame_ahead(logic [fsa_pkg::FrameW-1:0] a,
                                       logic [fsa_pkg::FrameW-1:0] b);
    logic [fsa_pkg::FrameW-1:0] delta;
    delta = a - b;
    return (delta != '0) && (delta < 32'h8000_0000);
  endfunction

  // Place one header into the slots and return the result it must produce
  function automatic fsa_pkg::out_beat_t place_packet(fsa_pkg::in_beat_t h);
    fsa_pkg::out_beat_t         res;
    logic                       cs;
    logic                       ns;
    logic                       tgt;
    logic [fsa_pkg::FrameW-1:0] f;
    res = '0;
    res.status = fsa_pkg::StAccepted;
    cs = live_slot;
    ns = ~live_slot;
    f = h.frame_number;
    if (h.run_number >= RUNS) begin
      res.status = fsa_pkg::StBadRun;
      return res;
    end
    if (h.packet_length != led_cfg[h.run_number[1:0]] * fsa_pkg::BytesPerLed
                           + fsa_pkg::HeaderBytes) begin
      res.status = fsa_pkg::StBadLen;
      return res;
    end
    if (f == slot_frame[cs] || slot_frame[cs] == '0) begin
      slot_frame[cs] = f;
      tgt = cs;
    end else if (f == slot_frame[ns]) begin
      tgt = ns;
    end else if (frame_ahead(f, slot_frame[cs])) begin
      if (slot_frame[ns] == '0 || frame_ahead(slot_frame[ns], f)) begin
        slot_frame[ns] = f;
        slot_runs[ns] = '0;
        tgt = ns;
      end else begin
        res.status = fsa_pkg::StNextOld;
        return res;
      end
    end else begin
      res.status = fsa_pkg::StStale;
      return res;
    end
    slot_runs[tgt] = slot_runs[tgt] | (4'b0001 << h.run_number[1:0]);
    res.dest_slot = tgt;
    res.frame_complete = &slot_runs[tgt];
    if (tgt == ns && res.frame_complete) begin
      live_slot = ns;
      slot_frame[cs] = '0;
      slot_runs[cs] = '0;
      res.slots_swapped = 1'b1;
    end
    return res;
  endfunction

  // Random header: mostly well-formed packets around a moving frame base
  function automatic fsa_pkg::in_beat_t make_header();
    fsa_pkg::in_beat_t h;
    int unsigned       pick;
    int unsigned       run;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      h.run_number = fsa_pkg::RunW'($urandom);
      h.packet_length = fsa_pkg::LenW'($urandom);
      h.frame_number = $urandom;
      return h;
    end
    run = $urandom_range(0, RUNS - 1);
    h.run_number = fsa_pkg::RunW'(run);
    h.packet_length = led_cfg[fsa_pkg::LedIdxW'(run)] * fsa_pkg::BytesPerLed
                      + fsa_pkg::HeaderBytes;
    // broken length on an otherwise good packet
    if (pick < 14) h.packet_length = h.packet_length + ((pick & 1) ? 16'd1 : 16'hFFFF);
    pick = $urandom_range(0, 99);
    if (pick < 55) h.frame_number = frame_base;
    else if (pick < 80) h.frame_number = frame_base + 32'd1;
    else if (pick < 86) h.frame_number = frame_base + 32'd2;
    else if (pick < 91) h.frame_number = frame_base - 32'd1;
    else if (pick < 93) h.frame_number = frame_base + 32'h7FFF_FFFF;
    else if (pick < 95) h.frame_number = frame_base + 32'h8000_0000;
    else if (pick < 97) h.frame_number = '0;
    else h.frame_number = $urandom;
    if ($urandom_range(0, 7) == 0) frame_base = frame_base + 32'd1;
    return h;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s at result %0d: got %0h, want %0h", what, results_seen, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(input fsa_pkg::out_beat_t got);
    fsa_pkg::out_beat_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result, status", got.status, 0);
      return;
    end
    want = pending_results.pop_front();
    if (got.status != want.status) report_mismatch("status", got.status, want.status);
    if (got.dest_slot != want.dest_slot)
      report_mismatch("dest_slot", got.dest_slot, want.dest_slot);
    if (got.frame_complete != want.frame_complete)
      report_mismatch("frame_complete", got.frame_complete, want.frame_complete);
    if (got.slots_swapped != want.slots_swapped)
      report_mismatch("slots_swapped", got.slots_swapped, want.slots_swapped);
  endtask

  // Write all LED counts from led_plan, then one write to an unused index
  task automatic load_leds();
    cfg_we_i <= 1'b1;
    for (int i = 0; i < fsa_pkg::NumLedRegs; i++) begin
      cfg_idx_i <= LED_REG[i];
      cfg_data_i <= led_plan[i];
      @(posedge clk_i);
      led_cfg[i] = led_plan[i];
    end
    cfg_idx_i <= fsa_pkg::CfgIdxW'($urandom_range(fsa_pkg::NumLedRegs,
                                                 (1 << fsa_pkg::CfgIdxW) - 1));
    cfg_data_i <= fsa_pkg::LedsW'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Send one header beat; the expectation is the typed one if given
  task automatic send_header(input fsa_pkg::in_beat_t h, input logic typed,
                             input fsa_pkg::out_beat_t want);
    fsa_pkg::out_beat_t predicted;
    int unsigned        gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= h;
    do @(posedge clk_i); while (in_stall_o);
    predicted = place_packet(h);
    pending_results.push_back(typed ? want : predicted);
    headers_sent++;
    status_hits[predicted.status]++;
    if (predicted.slots_swapped) swap_count++;
    if (predicted.frame_complete) complete_count++;
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Result side: check each beat, then draw a stall for the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_result(out_data_o);
        stall_left = $urandom_range(0, stall_max);
        if (stall_left != 0) out_stall_i <= 1'b1;
      end else if (out_stall_i) begin
        stall_left--;
        if (stall_left == 0) out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no handshake of any kind
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) idle = 0;
      else idle++;
    end
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("frame_slot_assembler regression: fail");
    $finish;
  end

  initial begin
    int unsigned r;
    for (int i = 0; i < fsa_pkg::NumLedRegs; i++) led_cfg[i] = '0;
    for (int i = 0; i < 8; i++) status_hits[i] = 0;
    slot_frame[0] = '0;
    slot_frame[1] = '0;
    slot_runs[0] = '0;
    slot_runs[1] = '0;
    live_slot = 1'b0;
    frame_base = '0;
    gap_max = 3;
    stall_max = 3;
    stall_left = 0;
    mismatch_count = 0;
    results_seen = 0;
    headers_sent = 0;
    swap_count = 0;
    complete_count = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extremes, every status, slot placement corner cases
    led_plan[0] = '0;
    led_plan[1] = '1;
    led_plan[2] = 10'd5;
    led_plan[3] = 10'd100;
    load_leds();
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_header(DIRECTED[i].hdr, DIRECTED[i].typed, DIRECTED[i].want);

    // Random phases, each with its own LED counts and idling pattern
    for (int p = 0; p < PHASES; p++) begin
      drain();
      for (int i = 0; i < fsa_pkg::NumLedRegs; i++) begin
        r = $urandom_range(0, 99);
        if (p == 0 || r < 20) led_plan[i] = '0;
        else if (p == 1 || r < 40) led_plan[i] = '1;
        else led_plan[i] = fsa_pkg::LedsW'($urandom);
      end
      load_leds();
      gap_max = (p % 3 == 1) ? 0 : 12;
      stall_max = (p % 4 == 2) ? 0 : 12;
      // every fourth phase jumps almost half the range ahead to walk through the wrap
      if (p % 4 == 1) frame_base = slot_frame[live_slot] + 32'h7FFF_FFF0;
      else frame_base = slot_frame[live_slot] + $urandom_range(0, 2);
      for (int n = 0; n < PHASE_HEADERS; n++)
        send_header(make_header(), 1'b0, NO_WANT);
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("sent %0d headers over %0d phases, %0d results checked, %0d mismatches",
             headers_sent, PHASES + 1, results_seen, mismatch_count);
    $display("accepted %0d, bad run %0d, bad length %0d, stale %0d, next older %0d",
             status_hits[fsa_pkg::StAccepted], status_hits[fsa_pkg::StBadRun],
             status_hits[fsa_pkg::StBadLen], status_hits[fsa_pkg::StStale],
             status_hits[fsa_pkg::StNextOld]);
    $display("%0d completed frames, %0d slot swaps", complete_count, swap_count);
    if (mismatch_count == 0) begin
      $display("frame_slot_assembler regression: pass");
    end else begin
      $display("frame_slot_assembler regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/fsa_pkg.sv
sv/fsa_place.sv
sv/frame_slot_assembler.sv
tb/tb_top.sv
